// File: src/assert_macros.svh
// Assertion macros used by the assertion checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define LPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define LPR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/lpr_pkg.sv
package lpr_pkg;

    // Fixed field widths of the frame table interface.
    localparam int FRAME_IDX_W = 4;
    localparam int CFG_W       = 5;
    localparam int COUNT_W     = 32;

    // Frame count after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } lpr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
    } lpr_status_t;

endpackage

// File: src/lpr_ram.sv
module lpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/lpr_ctrl.sv
module lpr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  lpr_pkg::lpr_status_t status,
    output lpr_pkg::lpr_cmd_t    cmd,
    output logic                 busy
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing: load the reference, scan the frames, finish the last
    // compare, then commit the update and the result.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: src/lpr_datapath.sv
module lpr_datapath #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lpr_pkg::lpr_cmd_t                  cmd,
    output lpr_pkg::lpr_status_t               status,
    input  logic [PAGE_BITS-1:0]               page_number,
    input  logic                               cfg_we,
    input  logic [lpr_pkg::CFG_W-1:0]          cfg_data,
    output logic                               done,
    output logic                               hit,
    output logic [lpr_pkg::FRAME_IDX_W-1:0]    frame_index,
    output logic                               evicted_valid,
    output logic [PAGE_BITS-1:0]               evicted_page,
    output logic [lpr_pkg::COUNT_W-1:0]        fault_count
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int OW = IW + 1;
    localparam logic [OW-1:0] OLD_EMPTY = OW'(MAX_FRAMES);
    localparam logic [IW-1:0] RANK_TOP  = IW'(MAX_FRAMES - 1);
    localparam logic [IW-1:0] IDX_TOP   = IW'(MAX_FRAMES - 1);

    // Configuration and per-transaction context.
    logic [lpr_pkg::CFG_W-1:0] frames_reg;
    logic [PAGE_BITS-1:0]      page_reg;
    logic [IW-1:0]             last_idx_reg;
    logic [IW-1:0]             last_idx_next;

    // Scan pipeline.
    logic [IW-1:0]             rd_idx_reg;
    logic                      cmp_vld_reg;
    logic [IW-1:0]             cmp_idx_reg;
    logic [PAGE_BITS-1:0]      ram_rdata;

    // Scan results.
    logic                      found_reg;
    logic [IW-1:0]             hit_idx_reg;
    logic [IW-1:0]             hit_rank_reg;
    logic                      empty_reg;
    logic [IW-1:0]             empty_idx_reg;
    logic [IW-1:0]             best_rank_reg;
    logic [IW-1:0]             victim_idx_reg;
    logic [PAGE_BITS-1:0]      victim_page_reg;

    // Frame state.
    logic                      valid_reg [MAX_FRAMES];
    logic                      valid_next [MAX_FRAMES];
    logic [IW-1:0]             rank_reg [MAX_FRAMES];
    logic [IW-1:0]             rank_next [MAX_FRAMES];
    logic [lpr_pkg::COUNT_W-1:0] fault_reg;

    // Result registers.
    logic                      done_reg;
    logic                      hit_out_reg;
    logic [lpr_pkg::FRAME_IDX_W-1:0] frame_out_reg;
    logic                      ev_valid_out_reg;
    logic [PAGE_BITS-1:0]      ev_page_out_reg;

    // Compare-stage and commit-stage helpers.
    logic                      cur_valid;
    logic [IW-1:0]             cur_rank;
    logic                      cur_match;
    logic [IW-1:0]             slot;
    logic [OW-1:0]             old_rank;
    logic                      is_evict;

    // Clamp the frame count to 1..MAX_FRAMES and keep the last index.
    always_comb
    begin
        priority if (frames_reg == '0)
        begin
            last_idx_next = '0;
        end
        else if (32'(frames_reg) > MAX_FRAMES)
        begin
            last_idx_next = IDX_TOP;
        end
        else
        begin
            last_idx_next = IW'(frames_reg - lpr_pkg::CFG_W'(1));
        end
    end

    // Frame count register, written over the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= lpr_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            frames_reg <= cfg_data;
        end
    end

    // Page storage: read one frame per cycle, write on a fault.
    lpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_page_ram (
        .clk   (clk),
        .we    (cmd.commit && !found_reg),
        .waddr (slot),
        .wdata (page_reg),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign status.scan_last = (rd_idx_reg == last_idx_reg);

    // State of the frame under compare; its page arrives from the RAM.
    assign cur_valid = valid_reg[cmp_idx_reg];
    assign cur_rank  = rank_reg[cmp_idx_reg];
    assign cur_match = cur_valid && (ram_rdata == page_reg);

    // Scan control and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg   <= '0;
            cmp_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            empty_reg    <= 1'b0;
            last_idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            rd_idx_reg   <= '0;
            cmp_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            empty_reg    <= 1'b0;
            last_idx_reg <= last_idx_next;
        end
        else
        begin
            if (cmd.issue)
            begin
                rd_idx_reg <= rd_idx_reg + IW'(1);
            end
            cmp_vld_reg <= cmd.issue;
            if (cmp_vld_reg && cur_match)
            begin
                found_reg <= 1'b1;
            end
            if (cmp_vld_reg && !cur_valid)
            begin
                empty_reg <= 1'b1;
            end
        end
    end

    // Scan payload: first match, first empty frame, oldest frame.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= rd_idx_reg;
        if (cmd.load)
        begin
            page_reg <= page_number;
        end
        if (cmp_vld_reg)
        begin
            if (cur_match && !found_reg)
            begin
                hit_idx_reg  <= cmp_idx_reg;
                hit_rank_reg <= cur_rank;
            end
            if (!cur_valid && !empty_reg)
            begin
                empty_idx_reg <= cmp_idx_reg;
            end
            if ((cmp_idx_reg == '0) || (cur_rank > best_rank_reg))
            begin
                best_rank_reg   <= cur_rank;
                victim_idx_reg  <= cmp_idx_reg;
                victim_page_reg <= ram_rdata;
            end
        end
    end

    // Frame chosen for this reference and its rank before the update.
    always_comb
    begin
        priority if (found_reg)
        begin
            slot     = hit_idx_reg;
            old_rank = {1'b0, hit_rank_reg};
        end
        else if (empty_reg)
        begin
            slot     = empty_idx_reg;
            old_rank = OLD_EMPTY;
        end
        else
        begin
            slot     = victim_idx_reg;
            old_rank = {1'b0, best_rank_reg};
        end
    end

    assign is_evict = !found_reg && !empty_reg;

    // Recency update: the chosen frame becomes newest, younger frames age.
    always_comb
    begin
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            rank_next[j]  = rank_reg[j];
            valid_next[j] = valid_reg[j];
            if (cmd.commit)
            begin
                if (IW'(j) == slot)
                begin
                    rank_next[j]  = '0;
                    valid_next[j] = 1'b1;
                end
                else if (valid_reg[j] && ({1'b0, rank_reg[j]} < old_rank) &&
                         (rank_reg[j] < RANK_TOP))
                begin
                    rank_next[j] = rank_reg[j] + IW'(1);
                end
            end
        end
    end

    // Frame state and the saturating fault counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_FRAMES; j++)
            begin
                valid_reg[j] <= 1'b0;
                rank_reg[j]  <= '0;
            end
            fault_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < MAX_FRAMES; j++)
            begin
                valid_reg[j] <= valid_next[j];
                rank_reg[j]  <= rank_next[j];
            end
            if (cmd.commit && !found_reg && (fault_reg != '1))
            begin
                fault_reg <= fault_reg + lpr_pkg::COUNT_W'(1);
            end
            done_reg <= cmd.commit;
        end
    end

    // Result payload, registered on the commit and held until the next commit.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_out_reg      <= found_reg;
            frame_out_reg    <= lpr_pkg::FRAME_IDX_W'(slot);
            ev_valid_out_reg <= is_evict;
            ev_page_out_reg  <= is_evict ? victim_page_reg : '0;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_out_reg;
    assign frame_index   = frame_out_reg;
    assign evicted_valid = ev_valid_out_reg;
    assign evicted_page  = ev_page_out_reg;
    assign fault_count   = fault_reg;

endmodule

// File: src/lru_page_replacement_core.sv
// Channel        Handshake                 Payload
// reference in   start, busy               page_number
// frame count    cfg_valid, cfg_ready      cfg_data
// result out     done (one-cycle strobe)   hit, frame_index, evicted_valid,
//                                          evicted_page, fault_count
//
// A reference is taken when start is high and busy is low; busy then stays
// high through the scan of the N frames, N being the clamped frame count,
// the last compare and the update, and the result strobe marks the first
// cycle with busy low again, when the next reference may already be taken.
// The page RAM is scanned one frame per cycle through its single read port.
// Reset empties every frame, clears the fault count and sets the frame count
// to 16. Frame count writes wait while busy or start is high; results cannot
// be stalled.
module lru_page_replacement_core #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [PAGE_BITS-1:0]            page_number,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]       cfg_data,
    output logic                            done,
    output logic                            hit,
    output logic [lpr_pkg::FRAME_IDX_W-1:0] frame_index,
    output logic                            evicted_valid,
    output logic [PAGE_BITS-1:0]            evicted_page,
    output logic [lpr_pkg::COUNT_W-1:0]     fault_count
);

    lpr_pkg::lpr_cmd_t    cmd;
    lpr_pkg::lpr_status_t status;

    // Configuration is taken only when no transaction is in flight or starting.
    assign cfg_ready = !busy && !start;

    // Sequencer.
    lpr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Frame table, recency order and fault counter.
    lpr_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .page_number   (page_number),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

endmodule

// File: src/lpr_checker.sv
`include "assert_macros.svh"

module lpr_assert_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        hit,
    input logic                        evicted_valid,
    input logic [lpr_pkg::COUNT_W-1:0] fault_count
);

    // A taken reference keeps the block busy in the next cycle.
    `LPR_ASSERT(a_start_busy, clk, rst_n, (start && !busy) |=> busy, "busy did not rise")

    // Each transaction gives one strobe, and only once the block is idle.
    `LPR_ASSERT(a_done_idle, clk, rst_n, done |-> (!busy && !$past(done)), "bad result strobe")

    // A hit never evicts a page.
    `LPR_ASSERT(a_hit_no_evict, clk, rst_n, (done && hit) |-> !evicted_valid, "hit with eviction")

    // The fault total never goes backward.
    `LPR_ASSERT(a_fault_mono, clk, rst_n,
                $past(rst_n) |-> (fault_count >= $past(fault_count)), "fault count fell")

    // While reset stays asserted, the fault total is zero.
    `LPR_ASSERT_ALWAYS(a_fault_reset, clk,
                       (!rst_n && !$past(rst_n)) |-> (fault_count == '0), "fault count not cleared")

endmodule

bind lru_page_replacement_core lpr_assert_checker u_lpr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .fault_count   (fault_count)
);

// File: sim/lpr_checker.sv
module lpr_checker #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [PAGE_BITS-1:0]            page_number,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            done,
    input  logic                            hit,
    input  logic [lpr_pkg::FRAME_IDX_W-1:0] frame_index,
    input  logic                            evicted_valid,
    input  logic [PAGE_BITS-1:0]            evicted_page,
    input  logic [lpr_pkg::COUNT_W-1:0]     fault_count,
    output int                              pending,
    output int                              failures
);

    // Everything one page reference reports back.
    typedef struct packed {
        logic                            hit;
        logic [lpr_pkg::FRAME_IDX_W-1:0] frame;
        logic                            evicted;
        logic [PAGE_BITS-1:0]            victim;
        logic [lpr_pkg::COUNT_W-1:0]     faults;
    } page_outcome_t;

    // Shadow copy of the frame table.
    logic [PAGE_BITS-1:0]        shadow_page [MAX_FRAMES];
    logic                        shadow_used [MAX_FRAMES];
    int unsigned                 shadow_age  [MAX_FRAMES];
    logic [lpr_pkg::COUNT_W-1:0] shadow_faults;
    logic [lpr_pkg::CFG_W-1:0]   shadow_frame_count;
    page_outcome_t               outcome_q [$];

    // A count of zero still searches one frame; large counts stop at the table size.
    function automatic int unsigned active_frames();
        if (shadow_frame_count == 0)
            return 1;
        if (shadow_frame_count > MAX_FRAMES)
            return MAX_FRAMES;
        return 32'(shadow_frame_count);
    endfunction

    // Move frame f to the front of the recency order; younger valid frames age by one.
    function automatic void make_newest(int unsigned f, bit was_used);
        int unsigned prior_age;
        prior_age = was_used ? shadow_age[f] : MAX_FRAMES;
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            if (j != f && shadow_used[j] && shadow_age[j] < prior_age &&
                shadow_age[j] < MAX_FRAMES - 1)
                shadow_age[j]++;
        end
        shadow_age[f]  = 0;
        shadow_used[f] = 1'b1;
    endfunction

    // Look a page up in the shadow table, update it, and return what the block should report.
    function automatic page_outcome_t lookup_page(logic [PAGE_BITS-1:0] pg);
        page_outcome_t r;
        int unsigned   n;
        int unsigned   slot;
        int unsigned   oldest;
        bit            found;
        bit            empty;
        r      = '0;
        n      = active_frames();
        slot   = 0;
        found  = 1'b0;
        empty  = 1'b0;
        // The lowest-index resident copy wins.
        for (int f = 0; f < n; f++)
        begin
            if (!found && shadow_used[f] && shadow_page[f] == pg)
            begin
                slot  = f;
                found = 1'b1;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            make_newest(slot, 1'b1);
        end
        else
        begin
            // Fill the lowest empty frame first.
            for (int f = 0; f < n; f++)
            begin
                if (!empty && !shadow_used[f])
                begin
                    slot  = f;
                    empty = 1'b1;
                end
            end
            // Otherwise replace the oldest frame, lowest index on a tie.
            if (!empty)
            begin
                oldest = 0;
                slot   = 0;
                for (int f = 0; f < n; f++)
                begin
                    if (shadow_age[f] > oldest)
                    begin
                        oldest = shadow_age[f];
                        slot   = f;
                    end
                end
                r.evicted = 1'b1;
                r.victim  = shadow_page[slot];
            end
            shadow_page[slot] = pg;
            make_newest(slot, !empty);
            if (shadow_faults != '1)
                shadow_faults++;
        end
        r.frame  = lpr_pkg::FRAME_IDX_W'(slot);
        r.faults = shadow_faults;
        return r;
    endfunction

    // Compare results, follow frame count writes, and predict each accepted reference.
    always @(posedge clk or negedge rst_n)
    begin
        page_outcome_t want;
        page_outcome_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                shadow_page[i] = '0;
                shadow_used[i] = 1'b0;
                shadow_age[i]  = 0;
            end
            shadow_faults      = '0;
            shadow_frame_count = lpr_pkg::CFG_RESET;
            outcome_q.delete();
            failures = 0;
        end
        else
        begin
            if (done)
            begin
                got = '{hit, frame_index, evicted_valid, evicted_page, fault_count};
                if (outcome_q.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $write("%0t: unexpected result ", $realtime);
                        $display("hit=%0b frame=%0d evicted=%0b page=%h faults=%0d",
                                 got.hit, got.frame, got.evicted, got.victim, got.faults);
                    end
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (want.hit !== got.hit || want.frame !== got.frame ||
                        want.evicted !== got.evicted || want.victim !== got.victim ||
                        want.faults !== got.faults)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $write("%0t: mismatch expected ", $realtime);
                            $write("hit=%0b frame=%0d evicted=%0b page=%h faults=%0d, ",
                                   want.hit, want.frame, want.evicted, want.victim,
                                   want.faults);
                            $display("got hit=%0b frame=%0d evicted=%0b page=%h faults=%0d",
                                     got.hit, got.frame, got.evicted, got.victim,
                                     got.faults);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                shadow_frame_count = cfg_data;
            if (start && !busy)
                outcome_q.push_back(lookup_page(page_number));
        end
        pending = outcome_q.size();
    end

endmodule

// File: sim/tb_lru_page_replacement_core.sv
module tb_lru_page_replacement_core;

    localparam int MAX_FRAMES       = 16;
    localparam int PAGE_BITS        = 16;
    localparam int REFERENCE_TARGET = 1950;
    localparam int DRAIN_CYCLES     = 40;
    localparam int POOL_DEPTH       = 40;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [PAGE_BITS-1:0]            page_number;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [lpr_pkg::CFG_W-1:0]       cfg_data;
    logic                            done;
    logic                            hit;
    logic [lpr_pkg::FRAME_IDX_W-1:0] frame_index;
    logic                            evicted_valid;
    logic [PAGE_BITS-1:0]            evicted_page;
    logic [lpr_pkg::COUNT_W-1:0]     fault_count;
    int                              outcomes_pending;
    int                              check_failures;

    // Stimulus shaping.
    int                     idle_pct;
    int                     refs_sent;
    logic [PAGE_BITS-1:0]   page_pool [POOL_DEPTH];

    // Clock: 12 time units per period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    lru_page_replacement_core #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page_number   (page_number),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

    lpr_checker #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page_number   (page_number),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count),
        .pending       (outcomes_pending),
        .failures      (check_failures)
    );

    // Issue one page reference; called and returns just after a falling edge.
    task automatic send_reference(input logic [PAGE_BITS-1:0] pg);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start       <= 1'b1;
        page_number <= pg;
        // The reference is accepted at the first rising edge with busy low.
        do
            @(posedge clk);
        while (busy);
        refs_sent++;
        @(negedge clk);
    endtask

    // Write the frame count once every outstanding result has come back.
    task automatic write_frame_count(input logic [lpr_pkg::CFG_W-1:0] value);
        start <= 1'b0;
        @(negedge clk);
        while (outcomes_pending != 0 || busy)
            @(negedge clk);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= lpr_pkg::CFG_W'($urandom);
        @(negedge clk);
    endtask

    // Hard stop in case the block hangs.
    initial
    begin
        #7_200_000;
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int          phase;
        int          active;
        int          pool_size;
        int          phase_refs;
        logic [lpr_pkg::CFG_W-1:0] count_value;
        logic [PAGE_BITS-1:0] pg;

        rst_n       = 1'b0;
        start       = 1'b0;
        page_number = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        idle_pct    = 29;
        refs_sent   = 0;
        for (int i = 0; i < POOL_DEPTH; i++)
            page_pool[i] = PAGE_BITS'($urandom);
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes and a first hit at the reset frame count.
        send_reference(16'h0000);
        send_reference(16'hFFFF);
        send_reference(16'h0000);
        send_reference(16'hAAAA);
        send_reference(16'h5555);
        // One frame: every new page evicts the last one.
        write_frame_count(5'd1);
        send_reference(16'h1234);
        send_reference(16'h1234);
        send_reference(16'hFFFF);
        // Two frames: the page now sits in both frames, the lower one hits.
        write_frame_count(5'd2);
        send_reference(16'hFFFF);
        send_reference(16'hAAAA);
        send_reference(16'h0000);
        // A zero count behaves as a single frame.
        write_frame_count(5'd0);
        send_reference(16'h0F0F);
        send_reference(16'h0F0F);
        // Counts above the table size clamp; hidden frames come back into view.
        write_frame_count(5'd31);
        send_reference(16'h8000);
        send_reference(16'h0001);
        send_reference(16'h5555);
        send_reference(16'hAAAA);
        send_reference(16'h1234);
        send_reference(16'h0000);

        // Random phases: a frame count, then references drawn mostly from a
        // working set a little larger than the frame count.
        phase = 0;
        while (refs_sent < REFERENCE_TARGET)
        begin
            phase++;
            idle_pct = (phase == 4) ? 0 : 29;
            case ($urandom_range(9))
                0:       count_value = 5'd0;
                1:       count_value = 5'd1;
                2:       count_value = 5'd16;
                3:       count_value = 5'd31;
                default: count_value = lpr_pkg::CFG_W'($urandom_range(31));
            endcase
            write_frame_count(count_value);
            active = (count_value == 0) ? 1 :
                     (count_value > MAX_FRAMES) ? MAX_FRAMES : count_value;
            pool_size = active + $urandom_range(active + 2);
            // Keep part of the old working set so earlier residents still hit.
            for (int i = 0; i < pool_size; i++)
            begin
                if ($urandom_range(1) == 0)
                    page_pool[i] = PAGE_BITS'($urandom);
            end
            phase_refs = (phase == 4) ? 250 : $urandom_range(30, 120);
            repeat (phase_refs)
            begin
                if ($urandom_range(99) < 12)
                    pg = PAGE_BITS'($urandom);
                else
                    pg = page_pool[$urandom_range(pool_size - 1)];
                send_reference(pg);
            end
        end

        // Drain and give the verdict.
        start <= 1'b0;
        while (outcomes_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (check_failures == 0 && outcomes_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
